@@ hw/rtl/frs_pkg.sv @@
`default_nettype none
package frs_pkg;

	localparam int NCODES = 16;
	localparam int MAX_NEST_DEF = 10;
	localparam int IN_DEPTH = 2;
	localparam int OUT_DEPTH = 2;
	localparam int WALK_STEPS = 1024;
	localparam logic [31:0] ENDLESS_COUNT = 32'd999999999;

	localparam logic [1:0] PH_FETCH = 2'd0;
	localparam logic [1:0] PH_GCNT = 2'd1;
	localparam logic [1:0] PH_ECNT = 2'd2;
	localparam logic [1:0] PH_RUN = 2'd3;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_ECOUNT = 2'd1;
	localparam logic [1:0] KIND_GCOUNT = 2'd2;
	localparam logic [1:0] KIND_END = 2'd3;

	localparam logic [1:0] SRC_NONE = 2'd0;
	localparam logic [1:0] SRC_W32 = 2'd1;
	localparam logic [1:0] SRC_W16 = 2'd2;

	localparam logic [2:0] REG_LENGTH = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic first_byte;
		logic last_byte;
	} in_t;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0] size_code;
		logic [1:0] kind;
		logic [7:0] type_code;
		logic new_row;
		logic last;
	} res_t;

	function automatic logic [15:0] code_at(input logic [255:0] words, input logic [3:0] idx);
		code_at = words[{idx, 4'b0} +: 16];
	endfunction

	// {valid, size code}
	function automatic logic [2:0] type_size(input logic [7:0] t);
		case (t) inside
			8'd8, 8'd9, 8'd10: type_size = 3'b111;
			8'd1, 8'd2, 8'd11, 8'd12: type_size = 3'b110;
			8'd4, 8'd5: type_size = 3'b101;
			8'd3, 8'd6, 8'd7: type_size = 3'b100;
			default: type_size = 3'b000;
		endcase
	endfunction

	function automatic logic [4:0] prog_len(input logic [4:0] fl);
		if (fl == 5'd0)
			prog_len = 5'd1;
		else if (fl > 5'(NCODES))
			prog_len = 5'(NCODES);
		else
			prog_len = fl;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/frs_fifo.sv @@
`default_nettype none
module frs_fifo
	import frs_pkg::*;
#(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr,
	input wire logic [W-1:0] wdata,
	output logic full,
	input wire logic rd,
	output logic [W-1:0] rdata,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0] mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (do_rd)
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/frs_walker.sv @@
`default_nettype none
module frs_walker
	import frs_pkg::*;
#(
	parameter int MAX_NEST = MAX_NEST_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [255:0] words,
	input wire logic [4:0] fmt_len,
	input wire in_t in_item,
	input wire logic in_empty,
	output logic in_pop,
	output res_t res,
	output logic res_push,
	input wire logic res_full
);
	localparam int NW = $clog2(MAX_NEST + 1);
	localparam int LW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
	localparam int SW = $clog2(WALK_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_USE = 3'b100
	} state_t;

	state_t st_q, st_d;
	logic [SW-1:0] step_q, step_d;
	logic [4:0] pos_q, pos_d;
	logic [NW-1:0] nest_q, nest_d;
	logic [4:0] start_q [MAX_NEST];
	logic [4:0] start_d [MAX_NEST];
	logic [31:0] target_q [MAX_NEST];
	logic [31:0] target_d [MAX_NEST];
	logic [31:0] done_q [MAX_NEST];
	logic [31:0] done_d [MAX_NEST];
	logic [31:0] el_q, el_d;
	logic [7:0] ct_q, ct_d;
	logic [1:0] ph_q, ph_d;
	logic [63:0] asm_q, asm_d;
	logic [2:0] bi_q, bi_d;
	logic row_q, row_d;

	always_comb begin
		logic [4:0] n, np, pw;
		logic [15:0] code, pcode;
		logic [NW-1:0] lv;
		logic [LW-1:0] l, pi;
		logic [31:0] dn, use_v, el_n;
		logic [2:0] ts, w, bin;
		logic [3:0] nb;
		logic [1:0] src;
		logic [63:0] nasm, val;
		logic found, have, do_push, clear;
		logic [31:0] push_cnt;
		logic [4:0] push_start;

		st_d = st_q; step_d = step_q; pos_d = pos_q; nest_d = nest_q;
		start_d = start_q; target_d = target_q; done_d = done_q;
		el_d = el_q; ct_d = ct_q; ph_d = ph_q; asm_d = asm_q; bi_d = bi_q; row_d = row_q;
		in_pop = 1'b0; res_push = 1'b0; res = '0;
		n = prog_len(fmt_len);
		np = pos_q + 5'd1;
		pw = pos_q - 5'd1;
		code = code_at(words, np[3:0] - 4'd1);
		pcode = code_at(words, pw[3:0]);
		lv = nest_q - 1'b1;
		l = lv[LW-1:0];
		pi = nest_q[LW-1:0];
		dn = done_q[l] + 32'd1;
		ts = type_size(code[7:0]);
		found = 1'b0; have = 1'b0; do_push = 1'b0; clear = 1'b0;
		push_cnt = '0; push_start = '0;
		nasm = asm_q | ({56'b0, in_item.data_byte} << {bi_q, 3'b0});
		src = (pos_q != 5'd0) ? pcode[15:14] : SRC_NONE;
		w = (src == SRC_W32) ? 3'd4 : ((src == SRC_W16) ? 3'd2 : 3'd1);
		bin = bi_q + 3'd1;
		val = '0; use_v = '0; el_n = '0; nb = '0;

		case (st_q)
			ST_IDLE: begin
				if (!in_empty) begin
					step_d = '0;
					if (in_item.first_byte)
						clear = 1'b1;
					st_d = (in_item.first_byte || ph_q == PH_FETCH) ? ST_WALK : ST_USE;
				end
			end
			ST_WALK: begin
				if (np > n) begin
					pos_d = '0;
					row_d = 1'b1;
				end else begin
					pos_d = np;
					if (code == 16'd0) begin
						if (nest_q != '0) begin
							done_d[l] = dn;
							if (dn >= target_q[l])
								nest_d = lv;
							else
								pos_d = start_q[l];
						end
					end else begin
						asm_d = '0;
						bi_d = '0;
						if (code[7:0] == 8'd0) begin
							if (code[15:14] != SRC_NONE) begin
								ph_d = PH_GCNT;
								found = 1'b1;
							end else begin
								do_push = 1'b1;
								push_cnt = {26'b0, code[13:8]};
								push_start = np;
							end
						end else begin
							ct_d = code[7:0];
							if (nest_q != '0 && np == n - 5'd1 && np == start_q[l] + 5'd1) begin
								el_d = ENDLESS_COUNT;
								if (ts[2]) begin
									ph_d = PH_RUN;
									found = 1'b1;
								end
							end else if (code[13:8] == 6'd0) begin
								if (code[15:14] != SRC_NONE) begin
									ph_d = PH_ECNT;
									found = 1'b1;
								end
							end else if (ts[2]) begin
								el_d = {26'b0, code[13:8]};
								ph_d = PH_RUN;
								found = 1'b1;
							end
						end
					end
				end
				step_d = step_q + 1'b1;
				if (found || step_q == SW'(WALK_STEPS - 1))
					st_d = ST_USE;
			end
			ST_USE: begin
				if (!res_full) begin
					in_pop = 1'b1;
					st_d = ST_IDLE;
					ts = type_size(ct_q);
					if (ph_q == PH_GCNT || ph_q == PH_ECNT) begin
						if (bin >= w) begin
							case (w)
								3'd4: val = {{32{nasm[31]}}, nasm[31:0]};
								3'd2: val = {{48{nasm[15]}}, nasm[15:0]};
								default: val = {{56{nasm[7]}}, nasm[7:0]};
							endcase
							use_v = val[63] ? 32'd0 : val[31:0];
							have = 1'b1;
							res.value = val;
							res.size_code = (w == 3'd4) ? 2'd2 : ((w == 3'd2) ? 2'd1 : 2'd0);
							asm_d = '0;
							bi_d = '0;
							if (ph_q == PH_GCNT) begin
								res.kind = KIND_GCOUNT;
								do_push = 1'b1;
								push_cnt = use_v;
								push_start = pos_q;
								ph_d = PH_FETCH;
							end else begin
								res.kind = KIND_ECOUNT;
								res.type_code = ct_q;
								if (use_v != 32'd0 && ts[2]) begin
									el_d = use_v;
									ph_d = PH_RUN;
								end else
									ph_d = PH_FETCH;
							end
						end else begin
							asm_d = nasm;
							bi_d = bin;
						end
					end else if (ph_q == PH_RUN) begin
						nb = ts[2] ? (4'd1 << ts[1:0]) : 4'd1;
						if ({1'b0, bi_q} + 4'd1 >= nb) begin
							have = 1'b1;
							res.value = nasm;
							res.size_code = ts[2] ? ts[1:0] : 2'd0;
							res.kind = KIND_DATA;
							res.type_code = ct_q;
							asm_d = '0;
							bi_d = '0;
							el_n = (el_q != 32'd0) ? el_q - 32'd1 : 32'd0;
							el_d = el_n;
							if (el_n == 32'd0)
								ph_d = PH_FETCH;
						end else begin
							asm_d = nasm;
							bi_d = bin;
						end
					end
					if (have || in_item.last_byte) begin
						res_push = 1'b1;
						if (!have)
							res.kind = KIND_END;
						res.new_row = row_q;
						res.last = in_item.last_byte;
						row_d = 1'b0;
					end
					if (in_item.last_byte)
						clear = 1'b1;
				end
			end
			default: st_d = ST_IDLE;
		endcase

		if (do_push && nest_q < NW'(MAX_NEST)) begin
			start_d[pi] = push_start;
			target_d[pi] = push_cnt;
			done_d[pi] = '0;
			nest_d = nest_q + 1'b1;
		end
		if (clear) begin
			pos_d = '0; nest_d = '0; el_d = '0; ct_d = '0; ph_d = PH_FETCH;
			asm_d = '0; bi_d = '0; row_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		start_q <= start_d;
		target_q <= target_d;
		done_q <= done_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			step_q <= '0;
			pos_q <= '0;
			nest_q <= '0;
			el_q <= '0;
			ct_q <= '0;
			ph_q <= PH_FETCH;
			asm_q <= '0;
			bi_q <= '0;
			row_q <= 1'b0;
		end else begin
			st_q <= st_d;
			step_q <= step_d;
			pos_q <= pos_d;
			nest_q <= nest_d;
			el_q <= el_d;
			ct_q <= ct_d;
			ph_q <= ph_d;
			asm_q <= asm_d;
			bi_q <= bi_d;
			row_q <= row_d;
		end
	end

	a_nest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nest_q <= NW'(MAX_NEST)) else $error("nest level overflow");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 5'(NCODES)) else $error("format position out of range");
	a_push_use: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (st_q == ST_USE && in_pop)) else $error("result outside byte use");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_pop |=> st_q == ST_IDLE) else $error("byte use did not return to idle");
endmodule
`default_nettype wire

@@ hw/rtl/format_driven_record_splitter.sv @@
`default_nettype none
// Record splitter: bytes pushed in are split into typed elements and counts under a
// program of up to 16 format codes, which the user must write through the cfg port
// only while idle; the block does not enforce this. A short input queue decouples
// the pusher from the walker. A byte that the current code still needs goes from the
// idle state to the use state, where it is popped once the output queue has room; to
// reach the next code, the single-step format walker first walks the format (at most
// 1024 steps before the byte is dropped). Results wait in a two-deep output queue.
module format_driven_record_splitter
	import frs_pkg::*;
#(
	parameter int MAX_NEST = MAX_NEST_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [63:0] cfg_data,
	input wire logic [7:0] data_byte,
	input wire logic first_byte,
	input wire logic last_byte,
	input wire logic push,
	output logic full,
	output logic [63:0] value,
	output logic [1:0] size_code,
	output logic [1:0] kind,
	output logic [7:0] type_code,
	output logic new_row,
	output logic last,
	output logic empty,
	input wire logic pop
);
	logic [3:0][63:0] words_q;
	logic [4:0] len_q;
	in_t in_w, in_r;
	res_t res_w, res_r;
	logic in_empty, in_pop, res_push, res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= '0;
			len_q <= 5'd1;
		end else if (cfg_we) begin
			if (cfg_index < REG_LENGTH)
				words_q[cfg_index[1:0]] <= cfg_data;
			else if (cfg_index == REG_LENGTH)
				len_q <= cfg_data[4:0];
		end
	end

	assign in_w = '{data_byte: data_byte, first_byte: first_byte, last_byte: last_byte};

	frs_fifo #(.W($bits(in_t)), .DEPTH(IN_DEPTH)) u_in_q (
		.clk(clk), .arst_n(arst_n),
		.wr(push), .wdata(in_w), .full(full),
		.rd(in_pop), .rdata(in_r), .empty(in_empty)
	);

	frs_walker #(.MAX_NEST(MAX_NEST)) u_walker (
		.clk(clk), .arst_n(arst_n),
		.words(words_q), .fmt_len(len_q),
		.in_item(in_r), .in_empty(in_empty), .in_pop(in_pop),
		.res(res_w), .res_push(res_push), .res_full(res_full)
	);

	frs_fifo #(.W($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk(clk), .arst_n(arst_n),
		.wr(res_push), .wdata(res_w), .full(res_full),
		.rd(pop), .rdata(res_r), .empty(empty)
	);

	assign value = res_r.value;
	assign size_code = res_r.size_code;
	assign kind = res_r.kind;
	assign type_code = res_r.type_code;
	assign new_row = res_r.new_row;
	assign last = res_r.last;
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none
module testbench;
	import frs_pkg::*;

	localparam logic [1:0] SRC_W8 = 2'd3;
	localparam logic [2:0] REG_WORDS_LOW = 3'd0;
	localparam logic [7:0] T_GROUP = 8'd0;
	localparam logic [7:0] T_UINT32 = 8'd1;
	localparam logic [7:0] T_FLOAT = 8'd2;
	localparam logic [7:0] T_CHAR = 8'd3;
	localparam logic [7:0] T_SHORT = 8'd4;
	localparam logic [7:0] T_USHORT = 8'd5;
	localparam logic [7:0] T_BYTE = 8'd6;
	localparam logic [7:0] T_UBYTE = 8'd7;
	localparam logic [7:0] T_DOUBLE = 8'd8;
	localparam logic [7:0] T_LONG = 8'd9;
	localparam logic [7:0] T_ULONG = 8'd10;
	localparam logic [7:0] T_INT = 8'd11;
	localparam logic [7:0] T_UINT = 8'd12;
	localparam logic [7:0] T_IGNORED = 8'd13;
	localparam logic [15:0] GROUP_CLOSE = 16'h0000;
	localparam logic [7:0] SIZED_TYPES [12] = '{T_UINT32, T_FLOAT, T_CHAR, T_SHORT,
		T_USHORT, T_BYTE, T_UBYTE, T_DOUBLE, T_LONG, T_ULONG, T_INT, T_UINT};
	localparam int SETTLE_CYCLES = 2200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic [7:0] data_byte = '0;
	logic first_byte = 1'b0;
	logic last_byte = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty, new_row, last;
	logic [63:0] value;
	logic [1:0] size_code, kind;
	logic [7:0] type_code;

	format_driven_record_splitter dut (.*);

	always #2 clk = ~clk;

	// shadow of the block
	logic [15:0] codes [16];
	logic [4:0] fmt_len;
	int unsigned pos, lvl, elems_left, cur_type, phase, byte_idx, endless, row_flag;
	int unsigned grp_start [MAX_NEST_DEF];
	int unsigned grp_target [MAX_NEST_DEF];
	int unsigned grp_done [MAX_NEST_DEF];
	logic [63:0] assembly;

	res_t pending_results [$];
	int errors = 0;
	bit hold_req = 0;
	int hold_left = 0;
	int burst_left = 0;
	bit no_gaps = 0;

	function automatic logic [15:0] fc(logic [1:0] src, logic [5:0] cnt, logic [7:0] typ);
		return {src, cnt, typ};
	endfunction

	function automatic int elem_size(int unsigned t);
		case (t)
			T_DOUBLE, T_LONG, T_ULONG: return 3;
			T_UINT32, T_FLOAT, T_INT, T_UINT: return 2;
			T_SHORT, T_USHORT: return 1;
			T_CHAR, T_BYTE, T_UBYTE: return 0;
			default: return -1;
		endcase
	endfunction

	function automatic int unsigned active_len();
		if (fmt_len == 0) return 1;
		if (fmt_len > 16) return 16;
		return fmt_len;
	endfunction

	task automatic clear_walk();
		pos = 0; lvl = 0; elems_left = 0; cur_type = 0; phase = PH_FETCH;
		assembly = '0; byte_idx = 0; endless = 0; row_flag = 0;
		for (int i = 0; i < MAX_NEST_DEF; i++) begin
			grp_start[i] = 0; grp_target[i] = 0; grp_done[i] = 0;
		end
	endtask

	task automatic open_group(int unsigned cnt);
		if (lvl < MAX_NEST_DEF) begin
			grp_start[lvl] = pos; grp_target[lvl] = cnt; grp_done[lvl] = 0;
			lvl++;
		end
	endtask

	task automatic walk_format();
		int unsigned n, code, cnt, typ, src, l;
		n = active_len();
		for (int steps = 0; steps < WALK_STEPS; steps++) begin
			pos++;
			if (pos > n) begin
				pos = 0; row_flag = 1;
				continue;
			end
			code = codes[pos - 1];
			if (code == 0) begin
				if (lvl == 0) continue;
				l = lvl - 1;
				grp_done[l]++;
				if (grp_done[l] >= grp_target[l]) lvl--;
				else pos = grp_start[l];
				continue;
			end
			cnt = (code >> 8) & 'h3F;
			typ = code & 'hFF;
			src = (code >> 14) & 'h3;
			assembly = '0; byte_idx = 0;
			if (typ == 0) begin
				if (src != 0) begin phase = PH_GCNT; return; end
				open_group(cnt);
				continue;
			end
			cur_type = typ;
			if (lvl > 0 && pos == n - 1 && pos == grp_start[lvl - 1] + 1) begin
				endless = 1; elems_left = ENDLESS_COUNT;
				if (elem_size(typ) >= 0) begin phase = PH_RUN; return; end
				endless = 0;
				continue;
			end
			if (cnt == 0) begin
				if (src != 0) begin phase = PH_ECNT; return; end
				continue;
			end
			if (elem_size(typ) >= 0) begin
				elems_left = cnt; phase = PH_RUN;
				return;
			end
		end
	endtask

	task automatic split_byte(input logic [7:0] b, input logic f, input logic lb,
			output res_t r, output bit got);
		int unsigned src, w, bits, use_cnt, nbytes;
		int sz;
		logic [63:0] v;
		got = 0; v = '0;
		r = '{value: '0, size_code: '0, kind: KIND_END, type_code: '0, new_row: 0, last: 0};
		if (f) clear_walk();
		if (phase == PH_FETCH) walk_format();
		if (phase == PH_GCNT || phase == PH_ECNT) begin
			src = 0;
			if (pos >= 1) src = (codes[pos - 1] >> 14) & 'h3;
			w = src == SRC_W32 ? 4 : (src == SRC_W16 ? 2 : 1);
			assembly |= 64'(b) << ((byte_idx & 7) * 8);
			byte_idx++;
			if (byte_idx >= w) begin
				bits = w * 8;
				v = assembly & ((64'd1 << bits) - 1);
				if (v[bits - 1]) v |= ~64'd0 << bits;
				use_cnt = v[63] ? 0 : v[31:0];
				r.value = v;
				r.size_code = w == 4 ? 2'd2 : (w == 2 ? 2'd1 : 2'd0);
				got = 1; assembly = '0; byte_idx = 0;
				if (phase == PH_GCNT) begin
					r.kind = KIND_GCOUNT; r.type_code = '0;
					open_group(use_cnt);
					phase = PH_FETCH;
				end else begin
					r.kind = KIND_ECOUNT; r.type_code = cur_type[7:0];
					if (use_cnt > 0 && elem_size(cur_type) >= 0) begin
						elems_left = use_cnt; phase = PH_RUN;
					end else
						phase = PH_FETCH;
				end
			end
		end else if (phase == PH_RUN) begin
			sz = elem_size(cur_type);
			nbytes = sz < 0 ? 1 : (1 << sz);
			assembly |= 64'(b) << ((byte_idx & 7) * 8);
			if (byte_idx + 1 >= nbytes) begin
				r.value = assembly;
				r.size_code = sz < 0 ? 2'd0 : 2'(sz);
				r.kind = KIND_DATA; r.type_code = cur_type[7:0];
				got = 1; assembly = '0; byte_idx = 0;
				if (elems_left > 0) elems_left--;
				if (elems_left == 0) begin phase = PH_FETCH; endless = 0; end
			end else
				byte_idx++;
		end
		if (!got && !lb) return;
		if (!got) r = '{value: '0, size_code: '0, kind: KIND_END, type_code: '0,
			new_row: 0, last: 0};
		got = 1;
		r.new_row = row_flag[0];
		r.last = lb;
		row_flag = 0;
		if (lb) clear_walk();
	endtask

	task automatic push_byte(input logic [7:0] b, input logic f, input logic lb);
		res_t r;
		bit got;
		if (burst_left <= 0 && !no_gaps) begin
			push <= 1'b0;
			repeat (($urandom % 8 == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5))
				@(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		data_byte <= b; first_byte <= f; last_byte <= lb; push <= 1'b1;
		do @(posedge clk); while (full);
		split_byte(b, f, lb, r, got);
		if (got) pending_results.push_back(r);
	endtask

	task automatic drain();
		push <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_program(input logic [4:0] len);
		drain();
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_WORDS_LOW + 3'(i);
			cfg_data <= {codes[4 * i + 3], codes[4 * i + 2], codes[4 * i + 1], codes[4 * i]};
			@(posedge clk);
		end
		cfg_we <= 1'b1; cfg_index <= REG_LENGTH; cfg_data <= 64'(len);
		@(posedge clk);
		cfg_we <= 1'b0;
		fmt_len = len;
	endtask

	function automatic logic [7:0] biased_byte();
		return ($urandom % 10 < 6) ? 8'($urandom_range(0, 3)) : 8'($urandom);
	endfunction

	task automatic random_record(input int len, input bit noisy);
		bit f, lb;
		f = !(noisy && $urandom % 2);
		lb = !(noisy && $urandom % 2);
		for (int i = 0; i < len; i++)
			push_byte(biased_byte(), i == 0 ? f : 1'b0, i == len - 1 ? lb : 1'b0);
	endtask

	task automatic send_list(input logic [7:0] bytes [$]);
		foreach (bytes[i])
			push_byte(bytes[i], i == 0, i == bytes.size() - 1);
	endtask

	task automatic test_fixed_elements();
		codes = '{default: GROUP_CLOSE};
		codes[0] = fc(SRC_NONE, 2, T_UINT);
		codes[1] = fc(SRC_NONE, 1, T_SHORT);
		codes[2] = fc(SRC_NONE, 1, T_LONG);
		codes[3] = fc(SRC_NONE, 3, T_UBYTE);
		load_program(4);
		send_list('{8'h11});
		send_list('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01,
			8'h80, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h55});
		for (int i = 0; i < 4; i++) random_record($urandom_range(1, 30), 0);
	endtask

	task automatic test_counts_from_data();
		codes = '{default: GROUP_CLOSE};
		codes[0] = fc(SRC_W8, 0, T_GROUP);
		codes[1] = fc(SRC_W16, 0, T_SHORT);
		codes[2] = GROUP_CLOSE;
		codes[3] = fc(SRC_W32, 0, T_BYTE);
		load_program(4);
		send_list('{8'h02, 8'h01, 8'h00, 8'hAA, 8'hBB, 8'hFF, 8'hFF, 8'h00, 8'h00,
			8'h03, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h80});
		send_list('{8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h09});
		for (int i = 0; i < 6; i++) random_record($urandom_range(1, 20), 0);
	endtask

	task automatic test_endless_group();
		codes = '{default: GROUP_CLOSE};
		codes[0] = fc(SRC_NONE, 1, T_USHORT);
		codes[1] = fc(SRC_NONE, 1, T_GROUP);
		codes[2] = fc(SRC_NONE, 0, T_CHAR);
		codes[3] = GROUP_CLOSE;
		load_program(4);
		random_record(30, 0);
		random_record(5, 0);
	endtask

	task automatic test_walk_corners();
		codes = '{default: GROUP_CLOSE};
		for (int i = 1; i <= 11; i++) codes[i] = fc(SRC_NONE, 1, T_GROUP);
		codes[12] = fc(SRC_NONE, 5, T_IGNORED);
		codes[13] = fc(SRC_NONE, 1, T_DOUBLE);
		load_program(16);
		random_record(20, 0);
		codes = '{default: GROUP_CLOSE};
		codes[0] = fc(SRC_NONE, 3, T_IGNORED);
		load_program(1);
		send_list('{8'h01, 8'h02, 8'h03});
		codes[0] = fc(SRC_NONE, 1, T_CHAR);
		codes[1] = fc(SRC_NONE, 1, T_ULONG);
		load_program(0);
		random_record(6, 0);
		for (int i = 0; i < 16; i++) codes[i] = fc(SRC_NONE, 6'($urandom_range(1, 2)),
			SIZED_TYPES[$urandom % 12]);
		load_program(5'd31);
		random_record(25, 0);
	endtask

	task automatic test_backpressure();
		codes = '{default: GROUP_CLOSE};
		codes[0] = fc(SRC_NONE, 1, T_UBYTE);
		codes[1] = fc(SRC_NONE, 1, T_SHORT);
		load_program(2);
		no_gaps = 1;
		hold_req = 1;
		random_record(60, 0);
		no_gaps = 0;
		drain();
		random_record(10, 0);
	endtask

	function automatic logic [15:0] random_code();
		case ($urandom % 10)
			0, 1, 2, 3: return fc(SRC_NONE, 6'($urandom_range(1, 4)), SIZED_TYPES[$urandom % 12]);
			4: return fc(2'($urandom_range(1, 3)), 0, SIZED_TYPES[$urandom % 12]);
			5: return fc(SRC_NONE, 6'($urandom_range(1, 3)), T_GROUP);
			6: return fc(2'($urandom_range(1, 3)), 6'($urandom), T_GROUP);
			7: return GROUP_CLOSE;
			8: return 16'($urandom);
			default: return fc(2'($urandom), 6'($urandom), T_IGNORED);
		endcase
	endfunction

	task automatic test_random_programs();
		int sent;
		for (int p = 0; p < 10; p++) begin
			for (int i = 0; i < 16; i++) codes[i] = random_code();
			load_program(5'($urandom_range(1, 16)));
			no_gaps = ($urandom % 3 == 0);
			sent = 0;
			while (sent < 30) begin
				int len;
				len = $urandom_range(1, 24);
				random_record(len, $urandom % 10 == 0);
				sent += len;
			end
			no_gaps = 0;
		end
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else
			case ((($urandom % 4096) < 2048) ? 0 : $urandom % 3)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom);
				default: pop <= ($urandom % 4 == 0);
			endcase
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				if (errors < 10) $display("unexpected transaction: value %h kind %0d", value, kind);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (value !== want.value || size_code !== want.size_code || kind !== want.kind ||
						type_code !== want.type_code || new_row !== want.new_row ||
						last !== want.last) begin
					if (errors < 10)
						$display({"mismatch: exp v=%h sz=%0d k=%0d t=%0d row=%0d last=%0d,",
							" got v=%h sz=%0d k=%0d t=%0d row=%0d last=%0d"},
							want.value, want.size_code, want.kind, want.type_code,
							want.new_row, want.last, value, size_code, kind, type_code,
							new_row, last);
					errors++;
				end
			end
		end
	end

	initial begin
		#40000000;
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		codes = '{default: GROUP_CLOSE};
		fmt_len = 5'd1;
		clear_walk();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fixed_elements();
		test_counts_from_data();
		test_endless_group();
		test_walk_corners();
		test_backpressure();
		test_random_programs();
		drain();
		if (errors == 0 && pending_results.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
`default_nettype wire

@@ filelist.f @@
hw/rtl/frs_pkg.sv
hw/rtl/frs_fifo.sv
hw/rtl/frs_walker.sv
hw/rtl/format_driven_record_splitter.sv
verif/testbench.sv
